@@ design/assert_macros.svh @@
// Assertion macros for the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion lbl failed");

// Check cons in the cycle after ante.
`define ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion lbl failed");

`endif

@@ design/oladl_pkg.sv @@
// Types and constants of the ordered list block.
package oladl_pkg;

    localparam int VALUE_W = 32;
    localparam int POS_W   = 16;

    typedef enum logic [1:0] {
        MODE_APPEND = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_LIST   = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_FULL  = 3'd1,
        ST_EMPTY = 3'd2,
        ST_BOUND = 3'd3,
        ST_NEG   = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEL_RD,
        S_DEL_SHIFT,
        S_DEL_DONE,
        S_LIST
    } state_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        status_t            status;
        logic               last;
    } res_t;

    typedef struct packed {
        logic busy;
        logic empty;
        logic full;
    } ctrl_stat_t;

endpackage

@@ design/oladl_ram.sv @@
// Generic simple dual-port RAM with registered read.
module oladl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/oladl_ctrl.sv @@
// Sequencer for append, delete with shift, and list read-out over the entry RAM.
module oladl_ctrl #(
    parameter int DEPTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    output logic                          cmd_ready,
    input  logic [1:0]                    cmd_mode,
    input  logic [oladl_pkg::VALUE_W-1:0] cmd_value,
    input  logic [oladl_pkg::POS_W-1:0]   cmd_pos,
    output logic                          rslt_valid,
    input  logic                          rslt_ready,
    output oladl_pkg::res_t               rslt,
    output oladl_pkg::ctrl_stat_t         stat,
    output logic                          ram_we,
    output logic [$clog2(DEPTH)-1:0]      ram_waddr,
    output logic [oladl_pkg::VALUE_W-1:0] ram_wdata,
    output logic                          ram_re,
    output logic [$clog2(DEPTH)-1:0]      ram_raddr,
    input  logic [oladl_pkg::VALUE_W-1:0] ram_rdata
);
    import oladl_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    state_t             state_reg, state_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [VALUE_W-1:0] removed_reg, removed_next;

    logic [AW-1:0]      idx_inc;
    logic [CW-1:0]      idx_p1_c;
    logic [CW-1:0]      idx_p2_c;
    logic [POS_W-1:0]   count_w;
    logic               full;
    logic               empty;
    logic               list_last;

    assign idx_inc   = idx_reg + 1'b1;
    assign idx_p1_c  = CW'(idx_reg) + CW'(1);
    assign idx_p2_c  = CW'(idx_reg) + CW'(2);
    assign count_w   = POS_W'(count_reg);
    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign list_last = (idx_p1_c == count_reg);

    assign stat.busy  = (state_reg != S_IDLE);
    assign stat.empty = empty;
    assign stat.full  = full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        removed_reg <= removed_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        removed_next = removed_reg;
        cmd_ready    = 1'b0;
        rslt_valid   = 1'b0;
        rslt.value   = '0;
        rslt.status  = ST_OK;
        rslt.last    = 1'b1;
        ram_we       = 1'b0;
        ram_waddr    = count_reg[AW-1:0];
        ram_wdata    = cmd_value;
        ram_re       = 1'b0;
        ram_raddr    = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                cmd_ready = rslt_ready;
                if (cmd_valid && rslt_ready)
                begin
                    case (mode_t'(cmd_mode))
                        MODE_APPEND:
                        begin
                            rslt_valid = 1'b1;
                            if (full)
                            begin
                                rslt.status = ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        MODE_DELETE:
                        begin
                            if (cmd_pos[POS_W-1])
                            begin
                                rslt_valid  = 1'b1;
                                rslt.status = ST_NEG;
                            end
                            else if (empty)
                            begin
                                rslt_valid  = 1'b1;
                                rslt.status = ST_EMPTY;
                            end
                            else if (cmd_pos >= count_w)
                            begin
                                rslt_valid  = 1'b1;
                                rslt.status = ST_BOUND;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = cmd_pos[AW-1:0];
                                idx_next   = cmd_pos[AW-1:0];
                                state_next = S_DEL_RD;
                            end
                        end
                        MODE_LIST:
                        begin
                            if (empty)
                            begin
                                rslt_valid  = 1'b1;
                                rslt.status = ST_EMPTY;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = '0;
                                idx_next   = '0;
                                state_next = S_LIST;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_DEL_RD:
            begin
                removed_next = ram_rdata;
                if (idx_p1_c < count_reg)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = idx_inc;
                    state_next = S_DEL_SHIFT;
                end
                else
                begin
                    state_next = S_DEL_DONE;
                end
            end
            S_DEL_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = ram_rdata;
                idx_next  = idx_inc;
                if (idx_p2_c < count_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = idx_inc + 1'b1;
                end
                else
                begin
                    state_next = S_DEL_DONE;
                end
            end
            S_DEL_DONE:
            begin
                rslt_valid = 1'b1;
                rslt.value = removed_reg;
                if (rslt_ready)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_LIST:
            begin
                rslt_valid = 1'b1;
                rslt.value = ram_rdata;
                rslt.last  = list_last;
                if (rslt_ready)
                begin
                    if (list_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next  = idx_inc;
                        ram_re    = 1'b1;
                        ram_raddr = idx_inc;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ design/ordered_list_append_delete.sv @@
// Top level of the ordered list with rear append, positional delete and read-out.
//
//  channel  direction  handshake              payload
//  cmd      in         cmd_valid / cmd_ready  mode, value, position
//  res      out        res_valid / res_ready  item_value, status, last
//
// Append and every rejected command are answered straight from the idle state. A delete
// at position p reads that entry, moves each later entry down by one and then returns
// the removed value; a read-out returns the entries in order, one per result, via the single RAM read port.
// Reset clears the entry count and the control state; RAM contents are not cleared.
// A stalled result holds in the output register while the sequencer waits on it.
`include "assert_macros.svh"

module ordered_list_append_delete #(
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cmd_valid,
    output logic                                 cmd_ready,
    input  logic [1:0]                           mode,
    input  logic signed [oladl_pkg::VALUE_W-1:0] value,
    input  logic signed [oladl_pkg::POS_W-1:0]   position,
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output logic signed [oladl_pkg::VALUE_W-1:0] item_value,
    output logic [2:0]                           status,
    output logic                                 last
);
    import oladl_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic               rslt_valid;
    logic               rslt_ready;
    res_t               rslt;
    ctrl_stat_t         stat;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [VALUE_W-1:0] ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;

    logic               res_valid_reg;
    res_t               res_reg;

    oladl_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd_mode   (mode),
        .cmd_value  (value),
        .cmd_pos    (position),
        .rslt_valid (rslt_valid),
        .rslt_ready (rslt_ready),
        .rslt       (rslt),
        .stat       (stat),
        .ram_we     (ram_we),
        .ram_waddr  (ram_waddr),
        .ram_wdata  (ram_wdata),
        .ram_re     (ram_re),
        .ram_raddr  (ram_raddr),
        .ram_rdata  (ram_rdata)
    );

    oladl_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Output register: load when empty or being drained.
    assign rslt_ready = !res_valid_reg || res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (rslt_valid && rslt_ready)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rslt_valid && rslt_ready)
        begin
            res_reg <= rslt;
        end
    end

    assign res_valid  = res_valid_reg;
    assign item_value = res_reg.value;
    assign status     = res_reg.status;
    assign last       = res_reg.last;

    `ASSERT_IMP(a_full_not_empty, 1'b1, !(stat.full && stat.empty))
    `ASSERT_IMP(a_busy_blocks_cmd, stat.busy, !cmd_ready)
    `ASSERT_NXT(a_append_fills, cmd_valid && cmd_ready && mode == MODE_APPEND, !stat.empty)

endmodule

@@ test/oladl_checker.sv @@
// Checker for the ordered list block: predicts list results and compares them with the output.
module oladl_checker #(
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cmd_valid,
    input  logic                                 cmd_ready,
    input  logic [1:0]                           mode,
    input  logic signed [oladl_pkg::VALUE_W-1:0] value,
    input  logic signed [oladl_pkg::POS_W-1:0]   position,
    input  logic                                 res_valid,
    input  logic                                 res_ready,
    input  logic signed [oladl_pkg::VALUE_W-1:0] item_value,
    input  logic [2:0]                           status,
    input  logic                                 last,
    output int                                   fail_count,
    output int                                   pending
);
    import oladl_pkg::*;

    logic signed [VALUE_W-1:0] list_mem [DEPTH];
    int   list_len  = 0;
    int   n_fail    = 0;
    int   n_pending = 0;
    res_t expected_results [$];

    assign fail_count = n_fail;
    assign pending    = n_pending;

    task automatic predict_list_results(
        input logic [1:0]                m,
        input logic signed [VALUE_W-1:0] v,
        input logic signed [POS_W-1:0]   p
    );
        res_t r;
        int   idx;
        r.value  = '0;
        r.status = ST_OK;
        r.last   = 1'b1;
        idx      = p;
        case (m)
            MODE_APPEND:
            begin
                if (list_len >= DEPTH)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    list_mem[list_len] = v;
                    list_len++;
                end
                expected_results.push_back(r);
            end
            MODE_DELETE:
            begin
                if (idx < 0)
                begin
                    r.status = ST_NEG;
                end
                else if (list_len == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else if (idx >= list_len)
                begin
                    r.status = ST_BOUND;
                end
                else
                begin
                    r.value = list_mem[idx];
                    for (int i = idx; i < list_len - 1; i++)
                    begin
                        list_mem[i] = list_mem[i + 1];
                    end
                    list_len--;
                end
                expected_results.push_back(r);
            end
            MODE_LIST:
            begin
                if (list_len == 0)
                begin
                    r.status = ST_EMPTY;
                    expected_results.push_back(r);
                end
                else
                begin
                    for (int i = 0; i < list_len; i++)
                    begin
                        r.value = list_mem[i];
                        r.last  = (i == list_len - 1);
                        expected_results.push_back(r);
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        res_t want;
        if (rst_n)
        begin
            if (cmd_valid && cmd_ready)
            begin
                predict_list_results(mode, value, position);
            end
            if (res_valid && res_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    n_fail++;
                    if (n_fail <= 10)
                    begin
                        $display("unexpected result: item_value=%0d status=%0d last=%0b",
                                 item_value, status, last);
                    end
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (item_value !== want.value || status !== want.status
                        || last !== want.last)
                    begin
                        n_fail++;
                        if (n_fail <= 10)
                        begin
                            $display("mismatch: expected item_value=%0d status=%s last=%0b",
                                     $signed(want.value), want.status.name(), want.last);
                            $display("          actual   item_value=%0d status=%0d last=%0b",
                                     item_value, status, last);
                        end
                    end
                end
            end
            n_pending = expected_results.size();
        end
    end

endmodule

@@ test/tb_ordered_list_append_delete.sv @@
// Testbench top for the ordered list block: stimulus, result stalls and the verdict.
module tb_ordered_list_append_delete;
    import oladl_pkg::*;

    localparam int         DEPTH       = 16;
    localparam int         N_RANDOM    = 320;
    localparam int         CYCLE_LIMIT = 600000;
    localparam int         DRAIN_WAIT  = 64;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      cmd_valid = 1'b0;
    logic                      cmd_ready;
    logic [1:0]                mode      = '0;
    logic signed [VALUE_W-1:0] value     = '0;
    logic signed [POS_W-1:0]   position  = '0;
    logic                      res_valid;
    logic                      res_ready = 1'b0;
    logic signed [VALUE_W-1:0] item_value;
    logic [2:0]                status;
    logic                      last;

    int send_idle_pct = 24;
    int recv_idle_pct = 84;
    int n_sent        = 0;
    int list_len      = 0;
    int cycle_count   = 0;
    int fail_count;
    int pending;

    always #4 clk = ~clk;

    ordered_list_append_delete #(
        .DEPTH(DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .mode      (mode),
        .value     (value),
        .position  (position),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .item_value(item_value),
        .status    (status),
        .last      (last)
    );

    oladl_checker #(
        .DEPTH(DEPTH)
    ) checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .mode      (mode),
        .value     (value),
        .position  (position),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .item_value(item_value),
        .status    (status),
        .last      (last),
        .fail_count(fail_count),
        .pending   (pending)
    );

    always @(posedge clk)
    begin
        res_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic signed [VALUE_W-1:0] rand_value();
        case ($urandom_range(7))
            0:       return 32'sh8000_0000;
            1:       return 32'sh7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // hold valid and payload until the transfer, then track list length and idle phase
    task automatic send_cmd(
        input logic [1:0]                m,
        input logic signed [VALUE_W-1:0] v,
        input logic signed [POS_W-1:0]   p
    );
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        mode      <= m;
        value     <= v;
        position  <= p;
        do
            @(posedge clk);
        while (!cmd_ready);
        if (m == MODE_APPEND && list_len < DEPTH)
        begin
            list_len++;
        end
        else if (m == MODE_DELETE && p >= 0 && p < list_len)
        begin
            list_len--;
        end
        if (m != MODE_UNUSED)
        begin
            n_sent++;
        end
        send_idle_pct = (n_sent < 110) ? 24 : (n_sent < 220) ? 84 : 0;
        recv_idle_pct = (n_sent < 110) ? 84 : (n_sent < 220) ? 24 : 0;
    endtask

    initial
    begin
        int                      stop_at;
        int                      pick;
        logic signed [POS_W-1:0] pos;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_cmd(MODE_LIST, $urandom, POS_W'($urandom));
        send_cmd(MODE_DELETE, $urandom, 16'sd0);
        send_cmd(MODE_DELETE, $urandom, 16'sh8000);
        send_cmd(MODE_DELETE, $urandom, -16'sd1);
        send_cmd(MODE_APPEND, 32'sh8000_0000, POS_W'($urandom));
        send_cmd(MODE_APPEND, 32'sh7fff_ffff, POS_W'($urandom));
        send_cmd(MODE_APPEND, 32'sd0, POS_W'($urandom));
        send_cmd(MODE_APPEND, -32'sd1, POS_W'($urandom));
        send_cmd(MODE_LIST, $urandom, POS_W'($urandom));
        send_cmd(MODE_DELETE, $urandom, 16'sd32767);
        send_cmd(MODE_DELETE, $urandom, 16'sd4);
        send_cmd(MODE_DELETE, $urandom, 16'sd3);
        send_cmd(MODE_DELETE, $urandom, 16'sd0);
        send_cmd(MODE_UNUSED, $urandom, POS_W'($urandom));
        send_cmd(MODE_LIST, $urandom, POS_W'($urandom));
        send_cmd(MODE_DELETE, $urandom, 16'sd1);
        send_cmd(MODE_DELETE, $urandom, 16'sd0);
        send_cmd(MODE_DELETE, $urandom, 16'sd0);
        send_cmd(MODE_LIST, $urandom, POS_W'($urandom));

        stop_at = n_sent + N_RANDOM;
        while (n_sent < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                send_cmd(MODE_APPEND, rand_value(), POS_W'($urandom));
            end
            else if (pick < 65)
            begin
                pos = (list_len > 0) ? POS_W'($urandom_range(list_len - 1))
                                     : POS_W'($urandom);
                send_cmd(MODE_DELETE, $urandom, pos);
            end
            else if (pick < 75)
            begin
                send_cmd(MODE_DELETE, $urandom, POS_W'($urandom));
            end
            else if (pick < 85)
            begin
                send_cmd(MODE_DELETE, $urandom, POS_W'(list_len));
            end
            else if (pick < 95)
            begin
                send_cmd(MODE_LIST, $urandom, POS_W'($urandom));
            end
            else if (pick < 97)
            begin
                send_cmd(MODE_UNUSED, $urandom, POS_W'($urandom));
            end
            else if (pick < 98)
            begin
                while (list_len < DEPTH)
                begin
                    send_cmd(MODE_APPEND, rand_value(), POS_W'($urandom));
                end
                send_cmd(MODE_APPEND, rand_value(), POS_W'($urandom));
                send_cmd(MODE_LIST, $urandom, POS_W'($urandom));
            end
            else
            begin
                while (list_len > 0)
                begin
                    send_cmd(MODE_DELETE, $urandom, POS_W'($urandom_range(list_len - 1)));
                end
                send_cmd(MODE_DELETE, $urandom, 16'sd0);
                send_cmd(MODE_LIST, $urandom, POS_W'($urandom));
            end
        end
        cmd_valid <= 1'b0;

        repeat (DRAIN_WAIT) @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end

        if (fail_count == 0 && pending == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/oladl_pkg.sv
design/oladl_ram.sv
design/oladl_ctrl.sv
design/ordered_list_append_delete.sv
test/oladl_checker.sv
test/tb_ordered_list_append_delete.sv
